// ===== src/lts_pkg.sv =====
// lexical token scanner: shared types, token codes and character decoders
// no dependencies; imported by lexical_token_scanner
`timescale 1ns / 1ps

package lts_pkg;

    localparam int MAX_NAME_CHARS_DEF = 8;
    localparam int NUMBER_BITS_DEF    = 32;
    localparam int RESULT_DEPTH       = 4;
    localparam int TDATA_BITS         = 112;
    localparam int TUSER_BITS         = 16;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NAME,
        MODE_NUM,
        MODE_CHOPEN,
        MODE_CHGOT,
        MODE_OP
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EQ,
        OP_BANG,
        OP_LT,
        OP_GT,
        OP_AMP,
        OP_BAR
    } op_t;

    // token kinds
    localparam logic [5:0] KIND_TRUE   = 6'd4;
    localparam logic [5:0] KIND_FALSE  = 6'd5;
    localparam logic [5:0] KIND_NULL   = 6'd6;
    localparam logic [5:0] KIND_IDENT  = 6'd14;
    localparam logic [5:0] KIND_EOF    = 6'd15;
    localparam logic [5:0] KIND_NUM    = 6'd16;
    localparam logic [5:0] KIND_ERR    = 6'd17;
    localparam logic [5:0] KIND_CHLIT  = 6'd18;
    localparam logic [5:0] KIND_PLUS   = 6'd19;
    localparam logic [5:0] KIND_MINUS  = 6'd20;
    localparam logic [5:0] KIND_STAR   = 6'd21;
    localparam logic [5:0] KIND_SLASH  = 6'd22;
    localparam logic [5:0] KIND_EQEQ   = 6'd23;
    localparam logic [5:0] KIND_ASSIGN = 6'd24;
    localparam logic [5:0] KIND_NE     = 6'd25;
    localparam logic [5:0] KIND_NOT    = 6'd26;
    localparam logic [5:0] KIND_LE     = 6'd27;
    localparam logic [5:0] KIND_LT     = 6'd28;
    localparam logic [5:0] KIND_GE     = 6'd29;
    localparam logic [5:0] KIND_GT     = 6'd30;
    localparam logic [5:0] KIND_ANDAND = 6'd31;
    localparam logic [5:0] KIND_AMP    = 6'd32;
    localparam logic [5:0] KIND_OROR   = 6'd33;
    localparam logic [5:0] KIND_COMMA  = 6'd34;
    localparam logic [5:0] KIND_SEMI   = 6'd35;
    localparam logic [5:0] KIND_LBRACE = 6'd36;
    localparam logic [5:0] KIND_RBRACE = 6'd37;
    localparam logic [5:0] KIND_LPAREN = 6'd38;
    localparam logic [5:0] KIND_RPAREN = 6'd39;
    localparam logic [5:0] KIND_LBRACK = 6'd40;
    localparam logic [5:0] KIND_RBRACK = 6'd41;
    localparam logic [5:0] KIND_DOT    = 6'd42;
    localparam logic [5:0] KIND_AT     = 6'd43;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd2;
    localparam logic [2:0] ERR_LONE_BAR   = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    localparam int KW_COUNT = 14;

    // keyword text, first character in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0000_6c6f_6f62,  // bool
        64'h0000_0000_7261_6863,  // char
        64'h0000_0000_746e_6975,  // uint
        64'h0000_0000_6575_7274,  // true
        64'h0000_0065_736c_6166,  // false
        64'h0000_0000_6c6c_756e,  // null
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0065_6c69_6877,  // while
        64'h0000_6e72_7574_6572,  // return
        64'h0066_6564_6570_7974,  // typedef
        64'h0000_7463_7572_7473,  // struct
        64'h0000_0000_0077_656e   // new
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd4,
        8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd6, 8'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [63:0] value;
        logic [7:0]  length;
        logic        trunc;
        logic        usuf;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } token_t;

    function automatic token_t make_token(input logic [5:0] kind, input logic [2:0] err,
                                          input logic [63:0] value,
                                          input logic [15:0] line,
                                          input logic [15:0] column);
        token_t t;
        t        = '0;
        t.kind   = kind;
        t.err    = err;
        t.value  = value;
        t.line   = line;
        t.column = column;
        return t;
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [63:0] name,
                                                input logic [7:0] count,
                                                input logic ovf);
        logic [5:0] k;
        k = KIND_IDENT;
        if (!ovf)
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (name == KW_TEXT[i] && count == KW_LEN[i])
                begin
                    k = 6'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic op_t op_of(input logic [7:0] b);
        op_t op;
        unique case (b)
            8'h3d:   op = OP_EQ;
            8'h21:   op = OP_BANG;
            8'h3c:   op = OP_LT;
            8'h3e:   op = OP_GT;
            8'h26:   op = OP_AMP;
            CH_BAR:  op = OP_BAR;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] op_second(input op_t op);
        logic [7:0] c;
        unique case (op)
            OP_EQ, OP_BANG, OP_LT, OP_GT: c = 8'h3d;
            OP_AMP:                       c = 8'h26;
            OP_BAR:                       c = CH_BAR;
            default:                      c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] op_single(input op_t op);
        logic [5:0] k;
        unique case (op)
            OP_EQ:   k = KIND_ASSIGN;
            OP_BANG: k = KIND_NOT;
            OP_LT:   k = KIND_LT;
            OP_GT:   k = KIND_GT;
            OP_AMP:  k = KIND_AMP;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_double(input op_t op);
        logic [5:0] k;
        unique case (op)
            OP_EQ:   k = KIND_EQEQ;
            OP_BANG: k = KIND_NE;
            OP_LT:   k = KIND_LE;
            OP_GT:   k = KIND_GE;
            OP_AMP:  k = KIND_ANDAND;
            OP_BAR:  k = KIND_OROR;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

    // single-byte punctuators; KIND_ERR for anything else
    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        unique case (b)
            8'h2b:   k = KIND_PLUS;
            8'h2d:   k = KIND_MINUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_SLASH;
            8'h2c:   k = KIND_COMMA;
            8'h3b:   k = KIND_SEMI;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5b:   k = KIND_LBRACK;
            8'h5d:   k = KIND_RBRACK;
            8'h2e:   k = KIND_DOT;
            8'h40:   k = KIND_AT;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

// ===== src/lexical_token_scanner.sv =====
// Lexical token scanner. One source byte (or the end-of-input marker) is
// accepted per clock while input ready is high; the scanner state is updated
// in that same cycle and the up to two tokens it causes are pushed into a
// 4-word result queue. Input ready stays high while the queue has room for
// two tokens, so the block takes a byte every cycle as long as the output
// side drains one token per cycle; a byte that closes one token and emits
// another puts two tokens into the queue. Results are registered in the
// result queue and are presented from its head. Position is reported as
// saturating line and column, both from 1, and is returned to line 1,
// column 1 by end of input. No clearing pass after reset. Depends on lts_pkg.
`timescale 1ns / 1ps

module lexical_token_scanner #(
    parameter int MAX_NAME_CHARS = lts_pkg::MAX_NAME_CHARS_DEF,
    parameter int NUMBER_BITS    = lts_pkg::NUMBER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // source_byte
    input  logic                           s_axis_tlast,   // end_of_input
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // token_value, name_length, truncated, unsigned_suffix, start line,
    // start_column, zero fill
    output logic [lts_pkg::TDATA_BITS-1:0] m_axis_tdata,
    // token_kind, error_code, zero fill
    output logic [lts_pkg::TUSER_BITS-1:0] m_axis_tuser,
    output logic                           m_axis_tlast    // last_result
);

    import lts_pkg::*;

    localparam int NAME_W = 8 * MAX_NAME_CHARS;
    localparam int PTR_W  = $clog2(RESULT_DEPTH);
    localparam int CNT_W  = $clog2(RESULT_DEPTH + 1);

    // scanner state
    mode_t                  mode_reg, mode_next;
    op_t                    op_reg, op_next;
    logic [NAME_W-1:0]      name_reg, name_next;
    logic [7:0]             count_reg, count_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic [7:0]             lit_reg, lit_next;
    logic                   ovf_reg, ovf_next;
    logic [15:0]            line_reg, line_next;
    logic [15:0]            col_reg, col_next;
    logic [15:0]            tline_reg, tline_next;
    logic [15:0]            tcol_reg, tcol_next;

    // result queue
    token_t                 queue_reg [RESULT_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;

    token_t                 res0, res1;
    logic [1:0]             n_res;
    logic                   in_fire, out_fire;
    token_t                 head;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        logic [7:0]             b;
        logic                   is_alpha, is_digit, is_ws, is_name_ch;
        logic [15:0]            col_inc;
        logic [63:0]            name64;
        logic [5:0]             kw;
        token_t                 flush_tok;
        logic                   flush_vld;
        logic                   do_start;
        logic [7:0]             count_sat;
        logic [NUMBER_BITS+3:0] wide;
        logic [5:0]             sk;
        token_t                 st_tok;

        b          = s_axis_tdata;
        is_alpha   = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
        is_digit   = (b >= 8'h30 && b <= 8'h39);
        is_ws      = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        is_name_ch = is_alpha || is_digit || (b == CH_USCORE);
        col_inc    = col_reg + 16'((col_reg != 16'hffff));
        count_sat  = count_reg + 8'((count_reg != 8'hff));
        name64     = 64'(name_reg);
        kw         = keyword_kind(name64, count_reg, ovf_reg);
        wide       = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + (NUMBER_BITS + 4)'(b[3:0]);

        mode_next  = mode_reg;
        op_next    = op_reg;
        name_next  = name_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        lit_next   = lit_reg;
        ovf_next   = ovf_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        res0       = '0;
        res1       = '0;
        n_res      = 2'd0;
        do_start   = 1'b0;
        st_tok     = '0;
        sk         = single_kind(b);

        // token closed by whatever ends the pending one
        flush_tok = '0;
        flush_vld = 1'b1;
        unique case (mode_reg)
            MODE_NAME:
            begin
                flush_tok = make_token(kw, ERR_NONE, name64, tline_reg, tcol_reg);
                if (kw == KIND_TRUE)
                begin
                    flush_tok.value = 64'd1;
                end
                else if (kw == KIND_FALSE || kw == KIND_NULL)
                begin
                    flush_tok.value = 64'd0;
                end
                flush_tok.length = count_reg;
                flush_tok.trunc  = ovf_reg;
            end
            MODE_NUM:
            begin
                flush_tok = make_token(KIND_NUM, ERR_NONE, 64'(acc_reg), tline_reg, tcol_reg);
                flush_tok.length = count_reg;
                flush_tok.trunc  = ovf_reg;
            end
            MODE_CHOPEN:
                flush_tok = make_token(KIND_ERR, ERR_BAD_CHAR, 64'd0, tline_reg, tcol_reg);
            MODE_CHGOT:
                flush_tok = make_token(KIND_ERR, ERR_UNCLOSED, 64'(lit_reg),
                                       tline_reg, tcol_reg);
            MODE_OP:
            begin
                if (op_reg == OP_BAR)
                begin
                    flush_tok = make_token(KIND_ERR, ERR_LONE_BAR, 64'(CH_BAR),
                                           tline_reg, tcol_reg);
                end
                else
                begin
                    flush_tok = make_token(op_single(op_reg), ERR_NONE, 64'd0,
                                           tline_reg, tcol_reg);
                end
                flush_vld = (op_reg != OP_NONE);
            end
            default:
                flush_vld = 1'b0;
        endcase

        if (s_axis_tlast)
        begin
            if (flush_vld)
            begin
                res0  = flush_tok;
                res1  = make_token(KIND_EOF, ERR_NONE, 64'd0, line_reg, col_reg);
                n_res = 2'd2;
            end
            else
            begin
                res0  = make_token(KIND_EOF, ERR_NONE, 64'd0, line_reg, col_reg);
                n_res = 2'd1;
            end
            mode_next  = MODE_IDLE;
            op_next    = OP_NONE;
            line_next  = 16'd1;
            col_next   = 16'd1;
            tline_next = 16'd1;
            tcol_next  = 16'd1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NAME:
                begin
                    if (is_name_ch)
                    begin
                        if (count_reg < 8'(MAX_NAME_CHARS))
                        begin
                            for (int i = 0; i < MAX_NAME_CHARS; i++)
                            begin
                                if (count_reg == 8'(i))
                                begin
                                    name_next[8*i +: 8] = b;
                                end
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        count_next = count_sat;
                        col_next   = col_inc;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        if (wide[NUMBER_BITS+3:NUMBER_BITS] != 4'd0)
                        begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = wide[NUMBER_BITS-1:0];
                        end
                        count_next = count_sat;
                        col_next   = col_inc;
                    end
                    else if (b == CH_U)
                    begin
                        col_next   = col_inc;
                        count_next = count_sat;
                        res0 = make_token(KIND_NUM, ERR_NONE, 64'(acc_reg), tline_reg, tcol_reg);
                        res0.length = count_sat;
                        res0.trunc  = ovf_reg;
                        res0.usuf   = 1'b1;
                        n_res       = 2'd1;
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                MODE_CHOPEN:
                begin
                    if (b < PRINT_LO || b > PRINT_HI)
                    begin
                        res0  = make_token(KIND_ERR, ERR_BAD_CHAR, 64'(b), tline_reg, tcol_reg);
                        n_res = 2'd1;
                    end
                    else
                    begin
                        lit_next = b;
                        col_next = col_inc;
                    end
                    mode_next = (b < PRINT_LO || b > PRINT_HI) ? MODE_IDLE : MODE_CHGOT;
                end
                MODE_CHGOT:
                begin
                    if (b == CH_QUOTE)
                    begin
                        col_next = col_inc;
                        res0 = make_token(KIND_CHLIT, ERR_NONE, 64'(lit_reg),
                                          tline_reg, tcol_reg);
                    end
                    else
                    begin
                        res0 = make_token(KIND_ERR, ERR_UNCLOSED, 64'(lit_reg),
                                          tline_reg, tcol_reg);
                    end
                    n_res     = 2'd1;
                    mode_next = MODE_IDLE;
                end
                MODE_OP:
                begin
                    if (op_reg != OP_NONE && b == op_second(op_reg))
                    begin
                        col_next  = col_inc;
                        res0 = make_token(op_double(op_reg), ERR_NONE, 64'd0,
                                          tline_reg, tcol_reg);
                        n_res     = 2'd1;
                        mode_next = MODE_IDLE;
                        op_next   = OP_NONE;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                default:
                    do_start = 1'b1;
            endcase

            if (do_start)
            begin
                // close the pending token, then scan this byte as a fresh start
                if (flush_vld)
                begin
                    res0  = flush_tok;
                    n_res = 2'd1;
                end
                mode_next = MODE_IDLE;
                op_next   = OP_NONE;
                if (is_ws)
                begin
                    if (b == CH_LF)
                    begin
                        line_next = line_reg + 16'((line_reg != 16'hffff));
                        col_next  = 16'd1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
                else
                begin
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    col_next   = col_inc;
                    if (is_alpha || b == CH_USCORE)
                    begin
                        mode_next     = MODE_NAME;
                        name_next     = '0;
                        name_next[7:0] = b;
                        count_next    = 8'd1;
                        ovf_next      = 1'b0;
                    end
                    else if (is_digit)
                    begin
                        mode_next  = MODE_NUM;
                        acc_next   = NUMBER_BITS'(b[3:0]);
                        count_next = 8'd1;
                        ovf_next   = 1'b0;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_CHOPEN;
                    end
                    else if (op_of(b) != OP_NONE)
                    begin
                        mode_next = MODE_OP;
                        op_next   = op_of(b);
                    end
                    else
                    begin
                        if (sk != KIND_ERR)
                        begin
                            st_tok = make_token(sk, ERR_NONE, 64'd0, line_reg, col_reg);
                        end
                        else
                        begin
                            st_tok = make_token(KIND_ERR, ERR_UNEXPECTED, 64'(b),
                                                line_reg, col_reg);
                        end
                        if (n_res == 2'd0)
                        begin
                            res0 = st_tok;
                        end
                        else
                        begin
                            res1 = st_tok;
                        end
                        n_res = n_res + 2'd1;
                    end
                end
            end
        end

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    // queue control: take a word only with room for two tokens
    assign s_axis_tready = (fill_reg <= CNT_W'(RESULT_DEPTH - 2));
    assign m_axis_tvalid = (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
            fill_next   = fill_next + CNT_W'(n_res);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            fill_next   = fill_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            op_reg     <= OP_NONE;
            name_reg   <= '0;
            count_reg  <= '0;
            acc_reg    <= '0;
            lit_reg    <= '0;
            ovf_reg    <= 1'b0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd1;
            tline_reg  <= 16'd1;
            tcol_reg   <= 16'd1;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg  <= mode_next;
                op_reg    <= op_next;
                name_reg  <= name_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
                lit_reg   <= lit_next;
                ovf_reg   <= ovf_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                tline_reg <= tline_next;
                tcol_reg  <= tcol_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head         = queue_reg[rd_ptr_reg];
    assign m_axis_tdata = {6'd0, head.column, head.line, head.usuf, head.trunc,
                           head.length, head.value};
    assign m_axis_tuser = {7'd0, head.err, head.kind};
    assign m_axis_tlast = head.last;

`ifndef ASSERT_OFF
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(RESULT_DEPTH))
        else $error("result queue overfilled");

    a_ready_room : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> fill_reg <= CNT_W'(RESULT_DEPTH))
        else $error("word accepted without room for its tokens");

    a_eof_position : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=>
            (line_reg == 16'd1 && col_reg == 16'd1 && mode_reg == MODE_IDLE))
        else $error("position or mode not restored after end of input");

    a_eof_token : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> m_axis_tvalid)
        else $error("end of input produced no token");
`endif

endmodule

// ===== tb/lexical_token_scanner_test.sv =====
// stream testbench for the lexical token scanner: source bytes in, tokens out
// predicts every token with its own scanner model; needs lts_pkg and lexical_token_scanner
`timescale 1ns / 1ps

module lexical_token_scanner_test;

    import lts_pkg::*;

    localparam int          MAX_NAME = MAX_NAME_CHARS_DEF;
    localparam logic [63:0] NUM_CEIL = (NUMBER_BITS_DEF >= 64) ? '1 :
                                       ((64'd1 << NUMBER_BITS_DEF) - 64'd1);

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       quiet;   // no source gap after this word
    } src_word_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;
    logic [TUSER_BITS-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    lexical_token_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    src_word_t src_words [$];
    token_t    tokens_due [$];
    token_t    step_toks [$];
    int        words_made = 0;
    int        fail_count = 0;
    int        src_gap    = 0;
    int        sink_stall = 0;
    logic      calm       = 1'b0;

    string kw_names [KW_COUNT] = '{"int", "bool", "char", "uint", "true", "false", "null",
                                   "if", "else", "while", "return", "typedef", "struct",
                                   "new"};
    string name_set   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string op_heads   = "=!<>&|";
    string punct_set  = "+-*/,;{}()[].@";

    // scanner state as the predictor sees it
    mode_t       sc_mode  = MODE_IDLE;
    op_t         pend_op  = OP_NONE;
    logic [63:0] nm_chars = '0;
    logic [7:0]  nm_len   = '0;
    logic [63:0] num_acc  = '0;
    logic [7:0]  lit_ch   = '0;
    logic        ovf      = 1'b0;
    logic [15:0] pos_line = 16'd1;
    logic [15:0] cur_col  = 16'd1;
    logic [15:0] tok_line = 16'd1;
    logic [15:0] tok_col  = 16'd1;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void bump_col();
        if (cur_col != 16'hffff)
            cur_col++;
    endfunction

    function automatic void put_token(input logic [5:0] kind, input logic [2:0] err,
                                      input logic [63:0] value, input logic [7:0] len,
                                      input logic trunc, input logic usuf);
        token_t t;
        t        = '0;
        t.kind   = kind;
        t.err    = err;
        t.value  = value;
        t.length = len;
        t.trunc  = trunc;
        t.usuf   = usuf;
        t.line   = tok_line;
        t.column = tok_col;
        step_toks.push_back(t);
    endfunction

    function automatic op_t op_from(input logic [7:0] b);
        case (b)
            "=":     return OP_EQ;
            "!":     return OP_BANG;
            "<":     return OP_LT;
            ">":     return OP_GT;
            "&":     return OP_AMP;
            "|":     return OP_BAR;
            default: return OP_NONE;
        endcase
    endfunction

    function automatic logic [7:0] op_follow(input op_t op);
        if (op == OP_AMP)
            return "&";
        if (op == OP_BAR)
            return "|";
        return "=";
    endfunction

    function automatic logic [5:0] op_kind(input op_t op, input logic dbl);
        case (op)
            OP_EQ:   return dbl ? KIND_EQEQ : KIND_ASSIGN;
            OP_BANG: return dbl ? KIND_NE : KIND_NOT;
            OP_LT:   return dbl ? KIND_LE : KIND_LT;
            OP_GT:   return dbl ? KIND_GE : KIND_GT;
            OP_AMP:  return dbl ? KIND_ANDAND : KIND_AMP;
            OP_BAR:  return dbl ? KIND_OROR : KIND_ERR;
            default: return KIND_ERR;
        endcase
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        case (b)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            ",":     return KIND_COMMA;
            ";":     return KIND_SEMI;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "[":     return KIND_LBRACK;
            "]":     return KIND_RBRACK;
            ".":     return KIND_DOT;
            "@":     return KIND_AT;
            default: return KIND_ERR;
        endcase
    endfunction

    // keyword index doubles as its token kind
    function automatic logic [5:0] name_kind();
        logic [5:0] k;
        logic       hit;
        k = KIND_IDENT;
        if (!ovf)
        begin
            for (int w = 0; w < KW_COUNT; w++)
            begin
                if (kw_names[w].len() == int'(nm_len))
                begin
                    hit = 1'b1;
                    for (int i = 0; i < kw_names[w].len(); i++)
                        if (nm_chars[8*i +: 8] != kw_names[w][i])
                            hit = 1'b0;
                    if (hit)
                        k = 6'(w);
                end
            end
        end
        return k;
    endfunction

    function automatic void name_char(input logic [7:0] b);
        if (int'(nm_len) < MAX_NAME)
            nm_chars[8*int'(nm_len) +: 8] = b;
        else
            ovf = 1'b1;
        if (nm_len != 8'hff)
            nm_len++;
    endfunction

    function automatic void add_digit(input logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - "0");
        if (num_acc > (NUM_CEIL - d) / 10)
        begin
            num_acc = NUM_CEIL;
            ovf     = 1'b1;
        end
        else
            num_acc = num_acc * 10 + d;
        if (nm_len != 8'hff)
            nm_len++;
    endfunction

    function automatic void flush_pending();
        logic [5:0]  k;
        logic [63:0] v;
        case (sc_mode)
            MODE_NAME:
            begin
                k = name_kind();
                if (k == KIND_TRUE)
                    v = 64'd1;
                else if (k == KIND_FALSE || k == KIND_NULL)
                    v = '0;
                else
                    v = nm_chars;
                put_token(k, ERR_NONE, v, nm_len, ovf, 1'b0);
            end
            MODE_NUM:    put_token(KIND_NUM, ERR_NONE, num_acc, nm_len, ovf, 1'b0);
            MODE_CHOPEN: put_token(KIND_ERR, ERR_BAD_CHAR, '0, '0, 1'b0, 1'b0);
            MODE_CHGOT:  put_token(KIND_ERR, ERR_UNCLOSED, 64'(lit_ch), '0, 1'b0, 1'b0);
            MODE_OP:
            begin
                if (pend_op == OP_BAR)
                    put_token(KIND_ERR, ERR_LONE_BAR, 64'(CH_BAR), '0, 1'b0, 1'b0);
                else if (pend_op != OP_NONE)
                    put_token(op_kind(pend_op, 1'b0), ERR_NONE, '0, '0, 1'b0, 1'b0);
            end
            default: ;
        endcase
        sc_mode = MODE_IDLE;
        pend_op = OP_NONE;
    endfunction

    function automatic void begin_token(input logic [7:0] b);
        logic [5:0] k;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
        begin
            if (b == CH_LF)
            begin
                if (pos_line != 16'hffff)
                    pos_line++;
                cur_col = 16'd1;
            end
            else
                bump_col();
        end
        else
        begin
            tok_line = pos_line;
            tok_col  = cur_col;
            bump_col();
            if (is_alpha(b) || b == CH_USCORE)
            begin
                sc_mode  = MODE_NAME;
                nm_chars = '0;
                nm_len   = '0;
                ovf      = 1'b0;
                name_char(b);
            end
            else if (is_digit(b))
            begin
                sc_mode = MODE_NUM;
                num_acc = '0;
                nm_len  = '0;
                ovf     = 1'b0;
                add_digit(b);
            end
            else if (b == CH_QUOTE)
                sc_mode = MODE_CHOPEN;
            else if (op_from(b) != OP_NONE)
            begin
                sc_mode = MODE_OP;
                pend_op = op_from(b);
            end
            else
            begin
                k = punct_kind(b);
                if (k != KIND_ERR)
                    put_token(k, ERR_NONE, '0, '0, 1'b0, 1'b0);
                else
                    put_token(KIND_ERR, ERR_UNEXPECTED, 64'(b), '0, 1'b0, 1'b0);
            end
        end
    endfunction

    // advance the predicted scanner by one accepted word, queue its tokens
    function automatic void scan_byte(input logic [7:0] b, input logic eoi);
        token_t t;
        step_toks.delete();
        if (eoi)
        begin
            flush_pending();
            tok_line = pos_line;
            tok_col  = cur_col;
            put_token(KIND_EOF, ERR_NONE, '0, '0, 1'b0, 1'b0);
            pos_line = 16'd1;
            cur_col  = 16'd1;
            tok_line = 16'd1;
            tok_col  = 16'd1;
        end
        else
        begin
            case (sc_mode)
                MODE_NAME:
                begin
                    if (is_alpha(b) || is_digit(b) || b == CH_USCORE)
                    begin
                        name_char(b);
                        bump_col();
                    end
                    else
                    begin
                        flush_pending();
                        begin_token(b);
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(b))
                    begin
                        add_digit(b);
                        bump_col();
                    end
                    else if (b == CH_U)
                    begin
                        bump_col();
                        if (nm_len != 8'hff)
                            nm_len++;
                        put_token(KIND_NUM, ERR_NONE, num_acc, nm_len, ovf, 1'b1);
                        sc_mode = MODE_IDLE;
                    end
                    else
                    begin
                        flush_pending();
                        begin_token(b);
                    end
                end
                MODE_CHOPEN:
                begin
                    // a bad byte after the quote is swallowed without moving the position
                    if (b < PRINT_LO || b > PRINT_HI)
                        put_token(KIND_ERR, ERR_BAD_CHAR, 64'(b), '0, 1'b0, 1'b0);
                    else
                    begin
                        lit_ch = b;
                        bump_col();
                    end
                    sc_mode = (b < PRINT_LO || b > PRINT_HI) ? MODE_IDLE : MODE_CHGOT;
                end
                MODE_CHGOT:
                begin
                    if (b == CH_QUOTE)
                    begin
                        bump_col();
                        put_token(KIND_CHLIT, ERR_NONE, 64'(lit_ch), '0, 1'b0, 1'b0);
                    end
                    else
                        put_token(KIND_ERR, ERR_UNCLOSED, 64'(lit_ch), '0, 1'b0, 1'b0);
                    sc_mode = MODE_IDLE;
                end
                MODE_OP:
                begin
                    if (pend_op != OP_NONE && b == op_follow(pend_op))
                    begin
                        bump_col();
                        put_token(op_kind(pend_op, 1'b1), ERR_NONE, '0, '0, 1'b0, 1'b0);
                        sc_mode = MODE_IDLE;
                        pend_op = OP_NONE;
                    end
                    else
                    begin
                        flush_pending();
                        begin_token(b);
                    end
                end
                default:
                begin
                    sc_mode = MODE_IDLE;
                    begin_token(b);
                end
            endcase
        end
        if (step_toks.size() > 0)
        begin
            t      = step_toks.pop_back();
            t.last = 1'b1;
            step_toks.push_back(t);
        end
        foreach (step_toks[i])
            tokens_due.push_back(step_toks[i]);
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        src_word_t w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                scan_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (src_words.size() > 0)
                begin
                    w = src_words.pop_front();
                    s_axis_tdata  <= w.ch;
                    s_axis_tlast  <= w.eoi;
                    s_axis_tvalid <= 1'b1;
                    if (!w.quiet && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 5);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // token side
    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: token kind %0d with none expected", $time,
                             m_axis_tuser[5:0]);
                    fail_count++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    // tdata: value, length, truncated, u suffix, line, column
                    check_field("token_kind", want.kind, m_axis_tuser[5:0]);
                    check_field("error_code", want.err, m_axis_tuser[8:6]);
                    check_field("token_value", want.value, m_axis_tdata[63:0]);
                    check_field("name_length", want.length, m_axis_tdata[71:64]);
                    check_field("truncated", want.trunc, m_axis_tdata[72]);
                    check_field("unsigned_suffix", want.usuf, m_axis_tdata[73]);
                    check_field("token line", want.line, m_axis_tdata[89:74]);
                    check_field("start_column", want.column, m_axis_tdata[105:90]);
                    check_field("last_result", want.last, m_axis_tlast);
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_stall = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic put_word(input logic [7:0] ch, input logic eoi, input logic quiet);
        src_word_t w;
        w.ch    = ch;
        w.eoi   = eoi;
        w.quiet = quiet;
        src_words.push_back(w);
        words_made++;
    endtask

    task automatic put_text(input string s, input logic quiet);
        for (int i = 0; i < s.len(); i++)
            put_word(s[i], 1'b0, quiet);
    endtask

    function automatic logic [7:0] blank_char();
        int pick;
        pick = $urandom_range(0, 6);
        return (pick > 4) ? CH_SPACE : CH_TAB + 8'(pick);
    endfunction

    // one random lexeme, mostly well formed, sometimes broken or plain noise
    task automatic add_lexeme(input logic quiet);
        int         pick;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            put_text(kw_names[$urandom_range(0, KW_COUNT - 1)], quiet);
            if ($urandom_range(0, 3) == 0)
                put_word(name_set[$urandom_range(0, 62)], 1'b0, quiet);
        end
        else if (pick < 30)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 9) : $urandom_range(1, 12);
            put_word(name_set[$urandom_range(0, 52)], 1'b0, quiet);
            repeat (len - 1)
                put_word(name_set[$urandom_range(0, 62)], 1'b0, quiet);
        end
        else if (pick < 45)
        begin
            case ($urandom_range(0, 7))
                0:       put_text("4294967295", quiet);
                1:       put_text("4294967296", quiet);
                default:
                begin
                    len = $urandom_range(1, 12);
                    repeat (len)
                        put_word("0" + 8'($urandom_range(0, 9)), 1'b0, quiet);
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                put_word(CH_U, 1'b0, quiet);
        end
        else if (pick < 55)
        begin
            put_word(CH_QUOTE, 1'b0, quiet);
            case ($urandom_range(0, 3))
                0:
                begin
                    c = 8'($urandom_range(0, 159));
                    put_word((c < PRINT_LO) ? c : c + 8'd95, 1'b0, quiet);
                end
                1:
                begin
                    put_word(8'($urandom_range(32, 126)), 1'b0, quiet);
                    c = 8'($urandom_range(0, 255));
                    put_word((c == CH_QUOTE) ? CH_BAR : c, 1'b0, quiet);
                end
                default:
                begin
                    put_word(8'($urandom_range(32, 126)), 1'b0, quiet);
                    put_word(CH_QUOTE, 1'b0, quiet);
                end
            endcase
        end
        else if (pick < 70)
        begin
            c = op_heads[$urandom_range(0, 5)];
            put_word(c, 1'b0, quiet);
            if ($urandom_range(0, 1) == 0)
                put_word(op_follow(op_from(c)), 1'b0, quiet);
        end
        else if (pick < 80)
            put_word(punct_set[$urandom_range(0, 13)], 1'b0, quiet);
        else if (pick < 88)
            repeat ($urandom_range(1, 3))
                put_word(blank_char(), 1'b0, quiet);
        else if (pick < 96)
            put_word(8'($urandom_range(0, 255)), 1'b0, quiet);
        else if (pick < 98)
            put_word(8'($urandom_range(0, 255)), 1'b1, quiet);
        else
            repeat ($urandom_range(1, 3))
                put_word(CH_LF, 1'b0, quiet);
        if ($urandom_range(0, 1) == 0)
            put_word(blank_char(), 1'b0, quiet);
    endtask

    task automatic add_random(input int count, input logic quiet);
        int stop_at;
        stop_at = words_made + count;
        while (words_made < stop_at)
            add_lexeme(quiet);
        put_word(8'($urandom_range(0, 255)), 1'b1, quiet);
    endtask

    initial
    begin
        // directed: keyword value, suffixed number, char literal and both char errors,
        // lone bar, double operators, extreme bytes, flush of pending tokens at end
        put_text("true 12u'a'", 1'b0);
        put_word(CH_QUOTE, 1'b0, 1'b0);
        put_word(8'h01, 1'b0, 1'b0);
        put_text("'ab|x||!=>@", 1'b0);
        put_word(8'hff, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word("<", 1'b0, 1'b0);
        put_word(8'h00, 1'b1, 1'b0);

        // long name and long number run their lengths into saturation
        repeat (260)
            put_word("a", 1'b0, 1'b1);
        put_word(CH_SPACE, 1'b0, 1'b1);
        repeat (260)
            put_word("9", 1'b0, 1'b1);
        put_word(8'h00, 1'b1, 1'b1);

        add_random(350, 1'b0);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // sender holds off until every token so far has come out
        while (src_words.size() != 0 || s_axis_tvalid || tokens_due.size() != 0)
            @(posedge clk);
        calm = 1'b1;
        add_random(145, 1'b1);

        while (src_words.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && tokens_due.size() == 0)
            $display("PASS lexical_token_scanner");
        else
            $display("FAIL lexical_token_scanner");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL lexical_token_scanner");
        $finish;
    end

endmodule

// ===== files.f =====
src/lts_pkg.sv
src/lexical_token_scanner.sv
tb/lexical_token_scanner_test.sv
